// File: rtl/core/six_axis_velocity_ramp_macros.svh
// Assertion macros shared by the velocity ramp RTL.
`ifndef SIX_AXIS_VELOCITY_RAMP_MACROS_SVH
`define SIX_AXIS_VELOCITY_RAMP_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define SVR_ASSERT_SAME(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define SVR_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/core/svr_pkg.sv
// Shared types, constants and helpers for the six-axis velocity ramp.
package svr_pkg;

   // Geometry of the axis and level stores.
   localparam int AXES    = 6;
   localparam int AXIS_W  = 3;
   localparam int VEL_W   = 25;
   localparam int LVL_W   = 9;
   localparam int ROW_W   = 2 * LVL_W;
   localparam int ACC_W   = 24;
   localparam int ELP_W   = 16;
   localparam int BASE_W  = ACC_W + ELP_W;
   localparam int PROD_W  = LVL_W + BASE_W;
   localparam int STEP_W  = 25;
   localparam int DECAY_W = 24;
   localparam int CALC_W  = 27;
   localparam int CD_W    = 18;

   // Port widths.
   localparam int REQ_DATA_W = 32;
   localparam int REQ_USER_W = 2;
   localparam int RSP_DATA_W = 152;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 24;

   // Request field positions inside req_tdata.
   localparam int TGT_LSB = 0;
   localparam int LVL_LSB = 4;
   localparam int ELP_LSB = 13;
   localparam int SEND_BIT = AXES * VEL_W;

   localparam logic [LVL_W-1:0]     LEVEL_ONE     = 9'd256;
   localparam logic [3:0]           DIR_COUNT     = 4'd12;
   localparam logic [3:0]           GROUP_COUNT   = 4'd3;
   localparam logic signed [CD_W-1:0] SEND_INTERVAL = 18'sd3277;

   typedef enum logic [1:0] {
      FUNC_LEVEL = 2'd0,
      FUNC_STOP  = 2'd1,
      FUNC_TICK  = 2'd2
   } func_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_ROT_ACCEL  = 3'd0,
      REG_STR_ACCEL  = 3'd1,
      REG_FWD_ACCEL  = 3'd2,
      REG_ROT_LIMIT  = 3'd3,
      REG_SIDE_LIMIT = 3'd4,
      REG_VERT_LIMIT = 3'd5,
      REG_FWD_LIMIT  = 3'd6,
      REG_BACK_LIMIT = 3'd7
   } csr_index_type;

   localparam logic [AXIS_W-1:0] AX_PITCH = 3'd0;
   localparam logic [AXIS_W-1:0] AX_YAW   = 3'd1;
   localparam logic [AXIS_W-1:0] AX_ROLL  = 3'd2;
   localparam logic [AXIS_W-1:0] AX_FWD   = 3'd3;
   localparam logic [AXIS_W-1:0] AX_SIDE  = 3'd4;
   localparam logic [AXIS_W-1:0] AX_VERT  = 3'd5;

   localparam logic [1:0] GRP_ROT = 2'd0;
   localparam logic [1:0] GRP_STR = 2'd1;
   localparam logic [1:0] GRP_FWD = 2'd2;

   // Per-axis job handed from the sequencer to the datapath.
   typedef struct packed {
      logic                vld;
      logic [AXIS_W-1:0]   axis;
      logic                tick;
      logic                stop;
      logic [ACC_W-1:0]    accel;
      logic [ACC_W-1:0]    hi_mag;
      logic [ACC_W-1:0]    lo_mag;
      logic [ELP_W-1:0]    elapsed;
      logic                vel_ok;
      logic                lvl_ok;
   } axis_ctx_type;

   // Write-back of one finished axis.
   typedef struct packed {
      logic                    vld;
      logic [AXIS_W-1:0]       axis;
      logic signed [VEL_W-1:0] vel;
   } axis_wb_type;

   // Stop group that governs each axis.
   function automatic logic [1:0] axis_group(input logic [AXIS_W-1:0] axis);
      logic [1:0] grp;
      case (axis)
         AX_FWD:          grp = GRP_FWD;
         AX_SIDE, AX_VERT: grp = GRP_STR;
         default:         grp = GRP_ROT;
      endcase
      return grp;
   endfunction

endpackage

// File: rtl/core/svr_ram.sv
// Generic single-port-write, registered-read RAM.
module svr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // Write and registered read share the clock.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

// File: rtl/core/svr_axis_dp.sv
// Per-axis ramp datapath: step products, decay, clamping and write-back.
module svr_axis_dp (
   input  logic                        clock,
   input  logic                        reset,
   input  svr_pkg::axis_ctx_type       ctx,
   input  logic [svr_pkg::VEL_W-1:0]   vel_rd,
   input  logic [svr_pkg::ROW_W-1:0]   lvl_rd,
   output svr_pkg::axis_wb_type        wb
);
   import svr_pkg::*;

   axis_ctx_type            s1_ctx_ff, s1_ctx_in;
   logic [BASE_W-1:0]       base_ff, base_in;
   logic signed [VEL_W-1:0] v1_ff, v1_in;
   logic [LVL_W-1:0]        dn1_ff, dn1_in;
   logic [LVL_W-1:0]        up1_ff, up1_in;

   axis_ctx_type            s2_ctx_ff;
   logic signed [VEL_W-1:0] v2_ff;
   logic [STEP_W-1:0]       stdn_ff, stdn_in;
   logic [STEP_W-1:0]       stup_ff, stup_in;
   logic [DECAY_W-1:0]      decay_ff;

   logic [PROD_W-1:0]       prod_dn;
   logic [PROD_W-1:0]       prod_up;

   logic signed [CALC_W-1:0] v_x;
   logic signed [CALC_W-1:0] hi_x;
   logic signed [CALC_W-1:0] lo_x;
   logic signed [CALC_W-1:0] dec_x;
   logic signed [CALC_W-1:0] dn_x;
   logic signed [CALC_W-1:0] up_x;
   logic signed [CALC_W-1:0] t_x;
   logic signed [CALC_W-1:0] new_x;

   // Stage one: base step accel*dt; entries never written read as zero.
   always_comb begin
      s1_ctx_in = ctx;
      base_in   = BASE_W'(ctx.accel) * BASE_W'(ctx.elapsed);
      v1_in     = ctx.vel_ok ? signed'(vel_rd) : '0;
      dn1_in    = ctx.lvl_ok ? lvl_rd[LVL_W-1:0] : '0;
      up1_in    = ctx.lvl_ok ? lvl_rd[ROW_W-1:LVL_W] : '0;
   end

   // Stage two: level-scaled steps and the decay step.
   assign prod_dn = PROD_W'(dn1_ff) * PROD_W'(base_ff);
   assign prod_up = PROD_W'(up1_ff) * PROD_W'(base_ff);
   assign stdn_in = prod_dn[PROD_W-1:24];
   assign stup_in = prod_up[PROD_W-1:24];

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ctx_ff.vld <= 1'b0;
         s2_ctx_ff.vld <= 1'b0;
      end else begin
         s1_ctx_ff.vld <= s1_ctx_in.vld;
         s2_ctx_ff.vld <= s1_ctx_ff.vld;
      end
      s1_ctx_ff.axis    <= s1_ctx_in.axis;
      s1_ctx_ff.tick    <= s1_ctx_in.tick;
      s1_ctx_ff.stop    <= s1_ctx_in.stop;
      s1_ctx_ff.accel   <= s1_ctx_in.accel;
      s1_ctx_ff.hi_mag  <= s1_ctx_in.hi_mag;
      s1_ctx_ff.lo_mag  <= s1_ctx_in.lo_mag;
      s1_ctx_ff.elapsed <= s1_ctx_in.elapsed;
      s1_ctx_ff.vel_ok  <= s1_ctx_in.vel_ok;
      s1_ctx_ff.lvl_ok  <= s1_ctx_in.lvl_ok;
      base_ff <= base_in;
      v1_ff   <= v1_in;
      dn1_ff  <= dn1_in;
      up1_ff  <= up1_in;

      s2_ctx_ff.axis    <= s1_ctx_ff.axis;
      s2_ctx_ff.tick    <= s1_ctx_ff.tick;
      s2_ctx_ff.stop    <= s1_ctx_ff.stop;
      s2_ctx_ff.accel   <= s1_ctx_ff.accel;
      s2_ctx_ff.hi_mag  <= s1_ctx_ff.hi_mag;
      s2_ctx_ff.lo_mag  <= s1_ctx_ff.lo_mag;
      s2_ctx_ff.elapsed <= s1_ctx_ff.elapsed;
      s2_ctx_ff.vel_ok  <= s1_ctx_ff.vel_ok;
      s2_ctx_ff.lvl_ok  <= s1_ctx_ff.lvl_ok;
      v2_ff    <= v1_ff;
      stdn_ff  <= stdn_in;
      stup_ff  <= stup_in;
      decay_ff <= base_ff[BASE_W-1:16];
   end

   // Stage three: hold, decay toward zero, or ramp and clamp to the axis limits.
   always_comb begin
      v_x   = signed'({{(CALC_W-VEL_W){v2_ff[VEL_W-1]}}, v2_ff});
      hi_x  = signed'({{(CALC_W-ACC_W){1'b0}}, s2_ctx_ff.hi_mag});
      lo_x  = -signed'({{(CALC_W-ACC_W){1'b0}}, s2_ctx_ff.lo_mag});
      dec_x = signed'({{(CALC_W-DECAY_W){1'b0}}, decay_ff});
      dn_x  = signed'({{(CALC_W-STEP_W){1'b0}}, stdn_ff});
      up_x  = signed'({{(CALC_W-STEP_W){1'b0}}, stup_ff});
      t_x   = v_x;
      new_x = v_x;
      if (!s2_ctx_ff.tick) begin
         new_x = v_x;
      end else if (s2_ctx_ff.stop) begin
         if (v_x > 0) begin
            t_x   = v_x - dec_x;
            new_x = (t_x < 0) ? '0 : t_x;
         end else begin
            t_x   = v_x + dec_x;
            new_x = (t_x > 0) ? '0 : t_x;
         end
      end else if ((stup_ff == '0) == (stdn_ff == '0)) begin
         // Both directions active, or neither: the axis holds.
         new_x = v_x;
      end else if (stup_ff != '0) begin
         t_x   = v_x + up_x;
         new_x = (t_x > hi_x) ? hi_x : t_x;
      end else begin
         t_x   = v_x - dn_x;
         new_x = (t_x < lo_x) ? lo_x : t_x;
      end
   end

   assign wb.vld  = s2_ctx_ff.vld;
   assign wb.axis = s2_ctx_ff.axis;
   assign wb.vel  = new_x[VEL_W-1:0];

endmodule

// File: rtl/core/six_axis_velocity_ramp.sv
// Top level of the six-axis velocity ramp: sequencer, state memories and ports.
//
//  Channel   Direction  Handshake                 Payload
//  req       in         req_tvalid / req_tready   tuser func; tdata target, level, elapsed
//  rsp       out        rsp_tvalid / rsp_tready   tdata six velocities, send_due
//  csr       in         csr_wr_en                 csr_index, csr_wdata (24 bits)
//
// Every item sweeps all six axes through the velocity and level memories: one read
// per cycle, then three datapath stages; the sequencer steps through the memory sweep,
// the datapath drain and done, loads the result into the output register, and only
// then returns to idle to take the next item.
// A finished result waits in the output register while the next item is taken.
// Reset is synchronous; stores come out of reset as zero through per-row valid bits.
// A stalled rsp side holds the sweep's result until the output register frees up.
`include "six_axis_velocity_ramp_macros.svh"

module six_axis_velocity_ramp (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // tdata from bit 0: target[3:0], level[12:4], elapsed[28:13], zero pad
   input  logic [svr_pkg::REQ_DATA_W-1:0]    req_tdata,
   // tuser: func[1:0]
   input  logic [svr_pkg::REQ_USER_W-1:0]    req_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // tdata from bit 0: pitch_rate, yaw_rate, roll_rate, forward_speed,
   // side_speed, vertical_speed (25 bits each), send_due[150], zero pad
   output logic [svr_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   input  logic                              csr_wr_en,
   input  logic [svr_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [svr_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import svr_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_SWEEP = 4'b0010,
      ST_DRAIN = 4'b0100,
      ST_DONE  = 4'b1000
   } state_type;

   state_type state_ff, state_in;
   logic [AXIS_W-1:0] cnt_ff, cnt_in;

   // Configuration registers.
   logic [ACC_W-1:0] rot_accel_ff, str_accel_ff, fwd_accel_ff;
   logic [ACC_W-1:0] rot_lim_ff, side_lim_ff, vert_lim_ff, fwd_lim_ff, back_lim_ff;

   // Item in work.
   func_type          item_func_ff;
   logic [3:0]        item_target_ff;
   logic [LVL_W-1:0]  item_level_ff;
   logic [ELP_W-1:0]  item_elapsed_ff;
   logic              item_send_ff, item_send_in;

   logic [2:0]                stop_ff;
   logic signed [CD_W-1:0]    cd_ff, cd_in;
   logic signed [CD_W-1:0]    cd_diff, cd_wrap;

   logic [AXES-1:0] vel_ok_ff;
   logic [AXES-1:0] lvl_ok_ff;

   axis_ctx_type ctx_in, ctx_ff;
   axis_wb_type  wb;

   logic [VEL_W-1:0] vel_rd;
   logic [ROW_W-1:0] lvl_rd;
   logic [ROW_W-1:0] lvl_row;
   logic [ROW_W-1:0] lvl_wr_data;
   logic             lvl_we;

   logic signed [VEL_W-1:0] asm_ff [AXES];
   logic signed [VEL_W-1:0] out_vel_ff [AXES];
   logic                    out_send_ff;
   logic                    rsp_tvalid_ff;

   logic             req_fire;
   logic             out_free;
   func_type         req_func;
   logic [3:0]       req_target;
   logic [LVL_W-1:0] req_level;
   logic [LVL_W-1:0] req_level_sat;
   logic [ELP_W-1:0] req_elapsed;

   assign req_func      = func_type'(req_tuser);
   assign req_target    = req_tdata[LVL_LSB-1:TGT_LSB];
   assign req_level     = req_tdata[ELP_LSB-1:LVL_LSB];
   assign req_elapsed   = req_tdata[ELP_LSB+ELP_W-1:ELP_LSB];
   assign req_level_sat = (req_level > LEVEL_ONE) ? LEVEL_ONE : req_level;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign out_free   = !rsp_tvalid_ff || rsp_tready;

   // Send countdown for a tick item.
   always_comb begin
      cd_diff      = cd_ff - signed'({{(CD_W-ELP_W){1'b0}}, req_elapsed});
      cd_wrap      = cd_diff + SEND_INTERVAL;
      cd_in        = cd_ff;
      item_send_in = 1'b0;
      if (req_func == FUNC_TICK) begin
         if (cd_diff > 0) begin
            cd_in = cd_diff;
         end else begin
            item_send_in = 1'b1;
            cd_in        = (cd_wrap < 0) ? SEND_INTERVAL : cd_wrap;
         end
      end
   end

   // Sequencer: one memory read per axis, then wait for the last write-back and a free output register.
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      case (state_ff)
         ST_IDLE: begin
            cnt_in = '0;
            if (req_tvalid) begin
               state_in = ST_SWEEP;
            end
         end
         ST_SWEEP: begin
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == AXIS_W'(AXES - 1)) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (wb.vld && wb.axis == AXIS_W'(AXES - 1)) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Axis job: acceleration, limits and stop flag of the axis being read.
   always_comb begin
      ctx_in.vld     = (state_ff == ST_SWEEP);
      ctx_in.axis    = cnt_ff;
      ctx_in.tick    = (item_func_ff == FUNC_TICK);
      ctx_in.stop    = stop_ff[axis_group(cnt_ff)];
      ctx_in.elapsed = item_elapsed_ff;
      ctx_in.vel_ok  = vel_ok_ff[cnt_ff];
      ctx_in.lvl_ok  = lvl_ok_ff[cnt_ff];
      case (cnt_ff)
         AX_FWD: begin
            ctx_in.accel  = fwd_accel_ff;
            ctx_in.hi_mag = fwd_lim_ff;
            ctx_in.lo_mag = back_lim_ff;
         end
         AX_SIDE: begin
            ctx_in.accel  = str_accel_ff;
            ctx_in.hi_mag = side_lim_ff;
            ctx_in.lo_mag = side_lim_ff;
         end
         AX_VERT: begin
            ctx_in.accel  = str_accel_ff;
            ctx_in.hi_mag = vert_lim_ff;
            ctx_in.lo_mag = vert_lim_ff;
         end
         default: begin
            ctx_in.accel  = rot_accel_ff;
            ctx_in.hi_mag = rot_lim_ff;
            ctx_in.lo_mag = rot_lim_ff;
         end
      endcase
   end

   // Level update: read-modify-write of the row pair while the sweep passes it.
   always_comb begin
      lvl_row = ctx_ff.lvl_ok ? lvl_rd : '0;
      lvl_wr_data = item_target_ff[0] ? {item_level_ff, lvl_row[LVL_W-1:0]}
                                      : {lvl_row[ROW_W-1:LVL_W], item_level_ff};
      lvl_we = ctx_ff.vld && (item_func_ff == FUNC_LEVEL)
               && (item_target_ff < DIR_COUNT)
               && (item_target_ff[3:1] == ctx_ff.axis);
   end

   svr_ram #(
      .WIDTH(VEL_W),
      .DEPTH(AXES)
   ) u_vel_ram (
      .clock   (clock),
      .wr_en   (wb.vld),
      .wr_addr (wb.axis),
      .wr_data (wb.vel),
      .rd_addr (cnt_ff),
      .rd_data (vel_rd)
   );

   svr_ram #(
      .WIDTH(ROW_W),
      .DEPTH(AXES)
   ) u_lvl_ram (
      .clock   (clock),
      .wr_en   (lvl_we),
      .wr_addr (ctx_ff.axis),
      .wr_data (lvl_wr_data),
      .rd_addr (cnt_ff),
      .rd_data (lvl_rd)
   );

   svr_axis_dp u_dp (
      .clock  (clock),
      .reset  (reset),
      .ctx    (ctx_ff),
      .vel_rd (vel_rd),
      .lvl_rd (lvl_rd),
      .wb     (wb)
   );

   // Control state, configuration, stop flags and the axis job register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         cnt_ff        <= '0;
         ctx_ff.vld    <= 1'b0;
         vel_ok_ff     <= '0;
         lvl_ok_ff     <= '0;
         stop_ff       <= '0;
         cd_ff         <= SEND_INTERVAL;
         rsp_tvalid_ff <= 1'b0;
         rot_accel_ff  <= 24'd5760;
         str_accel_ff  <= 24'd12800;
         fwd_accel_ff  <= 24'd128000;
         rot_lim_ff    <= 24'd23040;
         side_lim_ff   <= 24'd128000;
         vert_lim_ff   <= 24'd128000;
         fwd_lim_ff    <= 24'd1280000;
         back_lim_ff   <= 24'd640000;
      end else begin
         state_ff   <= state_in;
         cnt_ff     <= cnt_in;
         ctx_ff.vld <= ctx_in.vld;
         if (wb.vld) begin
            vel_ok_ff[wb.axis] <= 1'b1;
         end
         if (lvl_we) begin
            lvl_ok_ff[ctx_ff.axis] <= 1'b1;
         end
         if (req_fire) begin
            cd_ff <= cd_in;
            if (req_func == FUNC_STOP && req_target < GROUP_COUNT) begin
               stop_ff[req_target[1:0]] <= req_level[0];
            end
         end
         if (state_ff == ST_DONE && out_free) begin
            rsp_tvalid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_tvalid_ff <= 1'b0;
         end
         if (csr_wr_en) begin
            case (csr_index)
               REG_ROT_ACCEL:  rot_accel_ff <= csr_wdata;
               REG_STR_ACCEL:  str_accel_ff <= csr_wdata;
               REG_FWD_ACCEL:  fwd_accel_ff <= csr_wdata;
               REG_ROT_LIMIT:  rot_lim_ff   <= csr_wdata;
               REG_SIDE_LIMIT: side_lim_ff  <= csr_wdata;
               REG_VERT_LIMIT: vert_lim_ff  <= csr_wdata;
               REG_FWD_LIMIT:  fwd_lim_ff   <= csr_wdata;
               REG_BACK_LIMIT: back_lim_ff  <= csr_wdata;
               default:        rot_accel_ff <= rot_accel_ff;
            endcase
         end
      end
      ctx_ff.axis    <= ctx_in.axis;
      ctx_ff.tick    <= ctx_in.tick;
      ctx_ff.stop    <= ctx_in.stop;
      ctx_ff.accel   <= ctx_in.accel;
      ctx_ff.hi_mag  <= ctx_in.hi_mag;
      ctx_ff.lo_mag  <= ctx_in.lo_mag;
      ctx_ff.elapsed <= ctx_in.elapsed;
      ctx_ff.vel_ok  <= ctx_in.vel_ok;
      ctx_ff.lvl_ok  <= ctx_in.lvl_ok;
   end

   // Item payload and result assembly.
   always_ff @(posedge clock) begin
      if (req_fire) begin
         item_func_ff    <= req_func;
         item_target_ff  <= req_target;
         item_level_ff   <= req_level_sat;
         item_elapsed_ff <= req_elapsed;
         item_send_ff    <= item_send_in;
      end
      if (wb.vld) begin
         asm_ff[wb.axis] <= wb.vel;
      end
      if (state_ff == ST_DONE && out_free) begin
         for (int i = 0; i < AXES; i++) begin
            out_vel_ff[i] <= asm_ff[i];
         end
         out_send_ff <= item_send_ff;
      end
   end

   // Output packing.
   always_comb begin
      rsp_tdata = '0;
      for (int i = 0; i < AXES; i++) begin
         rsp_tdata[i*VEL_W +: VEL_W] = out_vel_ff[i];
      end
      rsp_tdata[SEND_BIT] = out_send_ff;
   end

   assign rsp_tvalid = rsp_tvalid_ff;

   // Checks on the sequencer and the write paths.
   `SVR_ASSERT_NEXT(a_accept_starts_sweep, clock, reset, req_fire, state_ff == ST_SWEEP, "accepted item did not start a sweep")
   `SVR_ASSERT_SAME(a_wb_in_sweep, clock, reset, wb.vld, state_ff == ST_SWEEP || state_ff == ST_DRAIN, "axis write-back outside a sweep")
   `SVR_ASSERT_SAME(a_lvl_we_cmd, clock, reset, lvl_we, item_func_ff == FUNC_LEVEL, "level store written by a non-command item")
   `SVR_ASSERT_NEXT(a_done_loads, clock, reset, state_ff == ST_DONE && out_free, rsp_tvalid && state_ff == ST_IDLE, "finished item not loaded into the output register")

endmodule
